/* rtl/sds_pkg.sv */
package sds_pkg;

  // running total width and its saturation value
  localparam int TOT_W = 24;
  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEAD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISK_CYLINDERS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_RIGHT    = 2'd2;

  // reset value of disk_cylinders for the default cylinder width
  localparam logic [16:0] DISK_CYL_RESET = 17'h10000;

  typedef struct packed {
    logic store;       // write the accepted request
    logic start;       // begin a schedule run
    logic scan_start;  // restart a selection pass over the store
    logic scan_run;    // selection pass in progress
    logic emit_item;   // emit the selected request
    logic emit_edge;   // emit the travel to the disk edge
    logic phase_b;     // switch to the return sweep
    logic flush;       // release the held result as last of run
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic phase_b;
    logic at_edge;
    logic slot_free;
  } dp_status_t;

endpackage

/* rtl/sds_req_if.sv */
interface sds_req_if #(
  parameter int CYL_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [CYL_BITS-1:0] cylinder;
  logic                final_request;

  modport source (output valid, cylinder, final_request, input ready);
  modport sink (input valid, cylinder, final_request, output ready);
endinterface

/* rtl/sds_res_if.sv */
interface sds_res_if #(
  parameter int CYL_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic [CYL_BITS-1:0]      served_cylinder;
  logic                     edge_turn;
  logic [CYL_BITS-1:0]      step_distance;
  logic [sds_pkg::TOT_W-1:0] running_total;
  logic                     overflowed;
  logic                     last_of_run;

  modport source (output valid, served_cylinder, edge_turn, step_distance, running_total,
                  overflowed, last_of_run, input ready);
  modport sink (input valid, served_cylinder, edge_turn, step_distance, running_total,
                overflowed, last_of_run, output ready);
endinterface

/* rtl/sds_ctrl.sv */
module sds_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_final,
  output logic                in_ready,
  output sds_pkg::ctrl_cmd_t  cmd,
  input  sds_pkg::dp_status_t status
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_SCAN,
    S_DECIDE,
    S_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_LOAD);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.store = 1'b1;
          if (in_final) begin
            cmd.start      = 1'b1;
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status.found) begin
          if (status.slot_free) begin
            cmd.emit_item  = 1'b1;
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end else if (!status.phase_b) begin
          // end of the first sweep: travel to the edge unless already there
          if (status.at_edge) begin
            cmd.phase_b    = 1'b1;
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end else if (status.slot_free) begin
            cmd.emit_edge  = 1'b1;
            cmd.phase_b    = 1'b1;
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (status.slot_free) begin
          cmd.flush  = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/sds_datapath.sv */
module sds_datapath #(
  parameter int MAX_PENDING = 32,
  parameter int CYL_BITS    = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sds_pkg::ctrl_cmd_t   cmd,
  output sds_pkg::dp_status_t  status,
  input  logic [CYL_BITS-1:0]  in_cylinder,
  input  logic [CYL_BITS-1:0]  start_head,
  input  logic [CYL_BITS:0]    disk_cylinders,
  input  logic                 sweep_right,
  sds_res_if.source            res
);

  localparam int IDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
  localparam int CNT_W = $clog2(MAX_PENDING + 1);
  localparam int KEY_W = CYL_BITS + IDX_W;
  localparam int SUM_W = ((sds_pkg::TOT_W > CYL_BITS) ? sds_pkg::TOT_W : CYL_BITS) + 1;

  logic [CYL_BITS-1:0] request_store [MAX_PENDING];

  logic [CNT_W-1:0]          count;
  logic                      drop_flag;
  logic [CYL_BITS-1:0]       head_position;
  logic [sds_pkg::TOT_W-1:0] movement_total;
  logic                      phase_b;

  // selection pass
  logic [CNT_W-1:0]    rd_cnt;
  logic                rd_pend;
  logic [IDX_W-1:0]    rd_idx;
  logic [CYL_BITS-1:0] rd_data;
  logic                found;
  logic [KEY_W-1:0]    best_key;
  logic                last_valid;
  logic [KEY_W-1:0]    last_key;

  // pending result, held until it is known whether it is the last
  logic                      hold_full;
  logic [CYL_BITS-1:0]       hold_cyl;
  logic                      hold_edge;
  logic [CYL_BITS-1:0]       hold_dist;
  logic [sds_pkg::TOT_W-1:0] hold_total;
  logic                      hold_ovf;

  logic                      out_valid;
  logic [CYL_BITS-1:0]       out_cyl;
  logic                      out_edge;
  logic [CYL_BITS-1:0]       out_dist;
  logic [sds_pkg::TOT_W-1:0] out_total;
  logic                      out_ovf;
  logic                      out_last;

  logic [CYL_BITS:0]         edge_full;
  logic [CYL_BITS-1:0]       edge_cyl;
  logic [CYL_BITS-1:0]       edge_target;
  logic                      slot_free;
  logic                      emit;
  logic [CYL_BITS-1:0]       new_cyl;
  logic [CYL_BITS-1:0]       new_dist;
  logic [SUM_W-1:0]          new_sum;
  logic [sds_pkg::TOT_W-1:0] new_total;
  logic [KEY_W-1:0]          cand_key;
  logic                      in_first;
  logic                      ascending;
  logic                      eligible;
  logic                      better;

  // edge cylinder, capped at the largest cylinder value
  assign edge_full   = (disk_cylinders == '0) ? '0 : disk_cylinders - 1'b1;
  assign edge_cyl    = edge_full[CYL_BITS] ? {CYL_BITS{1'b1}} : edge_full[CYL_BITS-1:0];
  assign edge_target = sweep_right ? edge_cyl : '0;

  assign slot_free = !out_valid || res.ready;
  assign emit      = cmd.emit_item || cmd.emit_edge;

  assign new_cyl   = cmd.emit_edge ? edge_target : best_key[KEY_W-1:IDX_W];
  assign new_dist  = (new_cyl > head_position) ? new_cyl - head_position
                                               : head_position - new_cyl;
  assign new_sum   = SUM_W'(movement_total) + SUM_W'(new_dist);
  assign new_total = (new_sum > SUM_W'(sds_pkg::TOTAL_MAX)) ? sds_pkg::TOTAL_MAX
                                                            : new_sum[sds_pkg::TOT_W-1:0];

  // candidate ordering: value first, store index breaks ties
  assign cand_key  = {rd_data, rd_idx};
  assign in_first  = sweep_right ? (rd_data >= start_head) : (rd_data <= start_head);
  assign ascending = sweep_right ^ phase_b;
  assign eligible  = (phase_b ? !in_first : in_first) &&
                     (!last_valid || (ascending ? (cand_key > last_key)
                                                : (cand_key < last_key)));
  assign better    = !found || (ascending ? (cand_key < best_key) : (cand_key > best_key));

  assign status.scan_done = (rd_cnt == count) && !rd_pend;
  assign status.found     = found;
  assign status.phase_b   = phase_b;
  assign status.at_edge   = (head_position == edge_target);
  assign status.slot_free = slot_free;

  assign res.valid           = out_valid;
  assign res.served_cylinder = out_cyl;
  assign res.edge_turn       = out_edge;
  assign res.step_distance   = out_dist;
  assign res.running_total   = out_total;
  assign res.overflowed      = out_ovf;
  assign res.last_of_run     = out_last;

  // request store and its registered read port
  always_ff @(posedge clk) begin
    if (cmd.store && (count < CNT_W'(MAX_PENDING))) begin
      request_store[count[IDX_W-1:0]] <= in_cylinder;
    end
    rd_data <= request_store[rd_cnt[IDX_W-1:0]];
    rd_idx  <= rd_cnt[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      drop_flag      <= 1'b0;
      head_position  <= '0;
      movement_total <= '0;
      phase_b        <= 1'b0;
      rd_cnt         <= '0;
      rd_pend        <= 1'b0;
      found          <= 1'b0;
      last_valid     <= 1'b0;
      hold_full      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.store) begin
        if (count < CNT_W'(MAX_PENDING)) begin
          count <= count + 1'b1;
        end else begin
          drop_flag <= 1'b1;
        end
      end

      if (cmd.start) begin
        head_position  <= start_head;
        movement_total <= '0;
        phase_b        <= 1'b0;
        last_valid     <= 1'b0;
      end

      if (cmd.scan_start) begin
        rd_cnt  <= '0;
        rd_pend <= 1'b0;
        found   <= 1'b0;
      end else if (cmd.scan_run) begin
        if (rd_cnt < count) begin
          rd_cnt  <= rd_cnt + 1'b1;
          rd_pend <= 1'b1;
        end else begin
          rd_pend <= 1'b0;
        end
        if (rd_pend && eligible && better) begin
          found    <= 1'b1;
          best_key <= cand_key;
        end
      end

      if (out_valid && res.ready && !emit && !cmd.flush) begin
        out_valid <= 1'b0;
      end

      if (emit) begin
        head_position  <= new_cyl;
        movement_total <= new_total;
        if (cmd.emit_item) begin
          last_key   <= best_key;
          last_valid <= 1'b1;
        end
        // the previously held result now has a successor
        out_valid  <= hold_full;
        out_cyl    <= hold_cyl;
        out_edge   <= hold_edge;
        out_dist   <= hold_dist;
        out_total  <= hold_total;
        out_ovf    <= hold_ovf;
        out_last   <= 1'b0;
        hold_full  <= 1'b1;
        hold_cyl   <= new_cyl;
        hold_edge  <= cmd.emit_edge;
        hold_dist  <= new_dist;
        hold_total <= new_total;
        hold_ovf   <= drop_flag;
      end

      if (cmd.phase_b) begin
        phase_b    <= 1'b1;
        last_valid <= 1'b0;
      end

      if (cmd.flush) begin
        out_valid      <= hold_full;
        out_cyl        <= hold_cyl;
        out_edge       <= hold_edge;
        out_dist       <= hold_dist;
        out_total      <= hold_total;
        out_ovf        <= hold_ovf;
        out_last       <= 1'b1;
        hold_full      <= 1'b0;
        count          <= '0;
        drop_flag      <= 1'b0;
        movement_total <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_item || cmd.emit_edge) |-> slot_free)
    else $error("result emitted while output register occupied");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_item || cmd.emit_edge) |=> hold_full)
    else $error("emitted result not held");

  a_flush_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> (count == '0) && !drop_flag && !hold_full)
    else $error("run state not cleared after last result");
`endif

endmodule

/* rtl/scan_disk_scheduler_top.sv */
// SCAN (elevator) disk scheduler.
// req channel: cylinder requests, one transfer per cycle while loading. The transfer
// with final_request set is itself a request and starts the schedule; requests beyond
// MAX_PENDING are dropped and every result of that run shows overflowed.
// res channel: one transfer per served request, plus an edge_turn marker when the head
// travels to the disk edge; last_of_run marks the final result of the schedule.
// Configuration: cfg_we/cfg_index/cfg_data write start_head, disk_cylinders and
// sweep_right; write only while no schedule is running.
// Selection: each result needs one selection pass over all stored requests, followed by
// a decision step in S_DECIDE; the single read port of the request store reads the
// stored requests one after another during the pass.
// Requests are not taken while a schedule runs; the first result appears once the
// second has been selected (or the run ends), as each result is held to learn whether
// it is the last.
// When the receiver stalls, the result stays in the output register and selection
// pauses; a new request list may load while the final result still waits.
// Reset (rst, synchronous) clears the stored count, flags, output valid and sets the
// configuration to start_head 0, disk_cylinders 65536, sweep_right 1.
module scan_disk_scheduler_top #(
  parameter int MAX_PENDING = 32,
  parameter int CYL_BITS    = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [CYL_BITS:0]                cfg_data,
  sds_req_if.sink                          req,
  sds_res_if.source                        res
);

  logic [CYL_BITS-1:0] start_head;
  logic [CYL_BITS:0]   disk_cylinders;
  logic                sweep_right;

  sds_pkg::ctrl_cmd_t  cmd;
  sds_pkg::dp_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_head     <= '0;
      disk_cylinders <= (CYL_BITS + 1)'(1) << CYL_BITS;
      sweep_right    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        sds_pkg::REG_START_HEAD:     start_head     <= cfg_data[CYL_BITS-1:0];
        sds_pkg::REG_DISK_CYLINDERS: disk_cylinders <= cfg_data;
        sds_pkg::REG_SWEEP_RIGHT:    sweep_right    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  sds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_final (req.final_request),
    .in_ready (req.ready),
    .cmd      (cmd),
    .status   (status)
  );

  sds_datapath #(
    .MAX_PENDING (MAX_PENDING),
    .CYL_BITS    (CYL_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_cylinder    (req.cylinder),
    .start_head     (start_head),
    .disk_cylinders (disk_cylinders),
    .sweep_right    (sweep_right),
    .res            (res)
  );

endmodule

/* tb/scan_disk_scheduler_top_tb.sv */
module scan_disk_scheduler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PENDING  = 32;
  localparam int CYL_BITS     = 16;
  localparam int SETTLE_TICKS = 16;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [15:0]               served_cylinder;
    logic                      edge_turn;
    logic [15:0]               step_distance;
    logic [sds_pkg::TOT_W-1:0] running_total;
    logic                      overflowed;
    logic                      last_of_run;
  } sched_step_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [sds_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [CYL_BITS:0]             cfg_data;

  sds_req_if #(.CYL_BITS(CYL_BITS)) req_bus ();
  sds_res_if #(.CYL_BITS(CYL_BITS)) res_bus ();

  scan_disk_scheduler_top #(
    .MAX_PENDING(MAX_PENDING),
    .CYL_BITS   (CYL_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req_bus.sink),
    .res      (res_bus.source)
  );

  // scheduler mirror: pending list, drop flag, head and movement
  logic [15:0] pending_reqs[$];
  logic        drop_seen;
  logic [15:0] sim_head;
  logic [23:0] sim_total;
  logic [15:0] cfg_start;
  logic [16:0] cfg_disk;
  logic        cfg_right;

  sched_step_t expected_steps[$];

  int errors;
  int cycle_count = 0;
  int src_idle_pct;
  int sink_idle_pct;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("scan_disk_scheduler_top test failed");
      $finish;
    end
  end

  task automatic push_step(input logic [15:0] cyl, input logic turn);
    logic [15:0] step_dist;
    logic [24:0] sum;
    sched_step_t r;
    step_dist = (cyl > sim_head) ? cyl - sim_head : sim_head - cyl;
    sum = {1'b0, sim_total} + {9'd0, step_dist};
    sim_total = (sum > {1'b0, sds_pkg::TOTAL_MAX}) ? sds_pkg::TOTAL_MAX : sum[23:0];
    sim_head = cyl;
    r.served_cylinder = cyl;
    r.edge_turn       = turn;
    r.step_distance   = step_dist;
    r.running_total   = sim_total;
    r.overflowed      = drop_seen;
    r.last_of_run     = 1'b0;
    expected_steps.push_back(r);
  endtask

  task automatic predict_request(input logic [15:0] cyl, input logic fin);
    logic [15:0] sorted[$];
    logic [15:0] v;
    logic [16:0] edge_wide;
    logic [15:0] edge_cyl;
    logic [15:0] start;
    sched_step_t tail;
    int n;
    int j;
    if (pending_reqs.size() < MAX_PENDING) pending_reqs.push_back(cyl);
    else drop_seen = 1'b1;
    if (!fin) return;

    sorted = {};
    foreach (pending_reqs[i]) begin
      v = pending_reqs[i];
      j = sorted.size();
      sorted.push_back(v);
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    n = sorted.size();

    edge_wide = (cfg_disk == 17'd0) ? 17'd0 : cfg_disk - 17'd1;
    edge_cyl  = (edge_wide > 17'h0FFFF) ? 16'hFFFF : edge_wide[15:0];
    start     = cfg_start;
    sim_head  = start;
    sim_total = '0;

    if (cfg_right) begin
      for (int i = 0; i < n; i++)
        if (sorted[i] >= start) push_step(sorted[i], 1'b0);
      if (sim_head != edge_cyl) push_step(edge_cyl, 1'b1);
      for (int i = n - 1; i >= 0; i--)
        if (sorted[i] < start) push_step(sorted[i], 1'b0);
    end else begin
      for (int i = n - 1; i >= 0; i--)
        if (sorted[i] <= start) push_step(sorted[i], 1'b0);
      if (sim_head != 16'd0) push_step(16'd0, 1'b1);
      for (int i = 0; i < n; i++)
        if (sorted[i] > start) push_step(sorted[i], 1'b0);
    end
    tail = expected_steps[expected_steps.size()-1];
    tail.last_of_run = 1'b1;
    expected_steps[expected_steps.size()-1] = tail;

    pending_reqs = {};
    drop_seen    = 1'b0;
    sim_total    = '0;
  endtask

  task automatic check_result();
    sched_step_t got;
    sched_step_t want;
    got.served_cylinder = res_bus.served_cylinder;
    got.edge_turn       = res_bus.edge_turn;
    got.step_distance   = res_bus.step_distance;
    got.running_total   = res_bus.running_total;
    got.overflowed      = res_bus.overflowed;
    got.last_of_run     = res_bus.last_of_run;
    if (expected_steps.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: cyl %0d edge %0b dist %0d total %0d",
                 got.served_cylinder, got.edge_turn, got.step_distance, got.running_total);
    end else begin
      want = expected_steps.pop_front();
      if (got.served_cylinder !== want.served_cylinder || got.edge_turn !== want.edge_turn ||
          got.step_distance !== want.step_distance || got.running_total !== want.running_total ||
          got.overflowed !== want.overflowed || got.last_of_run !== want.last_of_run) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected cyl %0d edge %0b dist %0d total %0d ovf %0b last %0b",
                   want.served_cylinder, want.edge_turn, want.step_distance,
                   want.running_total, want.overflowed, want.last_of_run);
          $display("          actual   cyl %0d edge %0b dist %0d total %0d ovf %0b last %0b",
                   got.served_cylinder, got.edge_turn, got.step_distance,
                   got.running_total, got.overflowed, got.last_of_run);
        end
      end
    end
  endtask

  // result side: check each transfer, then pick ready for the next edge
  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready) check_result();
    res_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic send_request(input logic [15:0] cyl, input logic fin);
    if ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    req_bus.valid         <= 1'b1;
    req_bus.cylinder      <= cyl;
    req_bus.final_request <= fin;
    do @(posedge clk); while (!req_bus.ready);
    predict_request(cyl, fin);
  endtask

  task automatic wait_schedule_idle();
    req_bus.valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sds_pkg::CFG_IDX_W-1:0] idx,
                           input logic [CYL_BITS:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] sh, input logic [16:0] dc, input logic sr);
    wait_schedule_idle();
    write_reg(sds_pkg::REG_START_HEAD, {1'b0, sh});
    write_reg(sds_pkg::REG_DISK_CYLINDERS, dc);
    write_reg(sds_pkg::REG_SWEEP_RIGHT, {16'd0, sr});
    cfg_we    <= 1'b0;
    cfg_start = sh;
    cfg_disk  = dc;
    cfg_right = sr;
  endtask

  function automatic logic [15:0] pick_cylinder();
    logic [15:0] offs;
    logic [16:0] top_cyl;
    offs    = 16'($urandom_range(0, 8));
    top_cyl = cfg_disk - 17'd1;
    case ($urandom_range(7))
      0:       return cfg_start;
      1:       return 16'd0;
      2:       return 16'hFFFF;
      3:       return cfg_start + offs - 16'd4;
      4:       return top_cyl[15:0];
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic configure_random();
    logic [15:0] sh;
    logic [16:0] dc;
    case ($urandom_range(3))
      0:       sh = 16'd0;
      1:       sh = 16'hFFFF;
      2:       sh = 16'($urandom_range(0, 64));
      default: sh = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0:       dc = 17'd1;
      1:       dc = sds_pkg::DISK_CYL_RESET;
      2:       dc = 17'($urandom_range(1, 128));
      default: dc = 17'($urandom_range(1, 65536));
    endcase
    configure(sh, dc, 1'($urandom_range(1)));
  endtask

  // reset values: start 0, full disk, sweeping right; head request and edge request
  task automatic test_reset_config();
    send_request(16'd0, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd100, 1'b1);
  endtask

  // right sweep with a request on the head and one beyond the edge
  task automatic test_sweep_right();
    configure(16'd1000, 17'd5000, 1'b1);
    send_request(16'd1000, 1'b0);
    send_request(16'd200, 1'b0);
    send_request(16'd3000, 1'b0);
    send_request(16'd6000, 1'b1);
  endtask

  // left sweep reaching cylinder zero by request, so no edge marker
  task automatic test_sweep_left();
    configure(16'd1000, 17'd5000, 1'b0);
    send_request(16'd1000, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd400, 1'b1);
  endtask

  task automatic test_edge_limits();
    configure(16'd0, 17'd0, 1'b0);
    send_request(16'd0, 1'b1);
    configure(16'd0, 17'd0, 1'b1);
    send_request(16'd5, 1'b1);
    // edge capped at the top cylinder
    configure(16'hFFFF, 17'h1FFFF, 1'b1);
    send_request(16'hFFFF, 1'b1);
    configure(16'd500, 17'd1, 1'b1);
    send_request(16'd100, 1'b1);
    // marker as final result
    configure(16'd10, sds_pkg::DISK_CYL_RESET, 1'b1);
    send_request(16'd20, 1'b1);
  endtask

  // one more request than the store holds, the dropped one carrying final_request
  task automatic test_store_full();
    configure_random();
    for (int i = 0; i <= MAX_PENDING; i++)
      send_request(pick_cylinder(), i == MAX_PENDING);
  endtask

  task automatic test_random_runs(input int src_pct, input int sink_pct, input int budget);
    int sent;
    int len;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    sent = 0;
    while (sent < budget) begin
      // without a rewrite the next list loads behind the running schedule
      if ($urandom_range(1)) configure_random();
      len = ($urandom_range(11) == 0) ? $urandom_range(30, 35) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
        send_request(pick_cylinder(), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = sds_pkg::REG_START_HEAD;
    cfg_data              = '0;
    req_bus.valid         = 1'b0;
    req_bus.cylinder      = '0;
    req_bus.final_request = 1'b0;
    errors                = 0;
    src_idle_pct          = 15;
    sink_idle_pct         = 56;
    drop_seen             = 1'b0;
    sim_head              = '0;
    sim_total             = '0;
    cfg_start             = 16'd0;
    cfg_disk              = sds_pkg::DISK_CYL_RESET;
    cfg_right             = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_config();
    test_sweep_right();
    test_sweep_left();
    test_edge_limits();
    test_store_full();
    test_random_runs(15, 56, 17);
    test_random_runs(56, 15, 17);
    test_random_runs(0, 0, 17);

    wait_schedule_idle();
    if (errors == 0) begin
      $display("scan_disk_scheduler_top test passed");
    end else begin
      $display("scan_disk_scheduler_top test failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sds_pkg.sv
rtl/sds_req_if.sv
rtl/sds_res_if.sv
rtl/sds_ctrl.sv
rtl/sds_datapath.sv
rtl/scan_disk_scheduler_top.sv
tb/scan_disk_scheduler_top_tb.sv
